// ----- sv/csrgb16_pkg.sv -----
// ----------------------------------------------------------------------------
// csrgb16_pkg
// Shared types and constants of the color space to 16-bit RGB converter.
// ----------------------------------------------------------------------------
package csrgb16_pkg;

    // source space codes
    localparam logic [2:0] OP_HSV  = 3'd0;
    localparam logic [2:0] OP_HSL  = 3'd1;
    localparam logic [2:0] OP_CMYK = 3'd2;
    localparam logic [2:0] OP_HALF = 3'd3;

    localparam logic [15:0] UNORM_MAX = 16'hFFFF;
    localparam logic [15:0] HUE_GREY  = 16'hFFFF;
    localparam int unsigned SIXTH     = 6000;
    localparam int unsigned TURN      = 36000;

    // rounding offset: half of 6000 * 65535
    localparam logic [45:0] HALF_DEN    = 46'd196605000;
    // ceil(2^42 / 6000), exact for quotients below 2^29
    localparam logic [29:0] RECIP_SIXTH = 30'd733007752;

    // register stages from input to output
    localparam int unsigned STAGES = 8;

    typedef enum logic [1:0] {
        SEL_CALC,
        SEL_CALC_HSL,
        SEL_FIXED
    } t_sel;

    // per-pixel side data traveling beside the arithmetic
    typedef struct packed {
        t_sel        sel;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        bad;
    } t_side;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_prep_ld;

    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } t_div_ld;

endpackage

// ----- sv/csrgb16_prep.sv -----
// ----------------------------------------------------------------------------
// csrgb16_prep
// Stages 1 to 3: decode, hue sectors, products, and per-channel terms A, B, w.
// Each channel value is later round((A * 6000 - B * w) / (6000 * 65535)).
// ----------------------------------------------------------------------------
module csrgb16_prep
    import csrgb16_pkg::*;
(
    input  logic        i_clk,
    input  t_prep_ld    i_ld,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_alpha_in,
    input  logic [15:0] i_chan_a,
    input  logic [15:0] i_chan_b,
    input  logic [15:0] i_chan_c,
    input  logic [15:0] i_chan_d,
    output logic [31:0] o_a_red,
    output logic [31:0] o_a_green,
    output logic [31:0] o_a_blue,
    output logic [31:0] o_b,
    output logic [12:0] o_w_red,
    output logic [12:0] o_w_green,
    output logic [12:0] o_w_blue,
    output t_side       o_side
);

    typedef enum logic [1:0] {
        MODE_HSV,
        MODE_HSL,
        MODE_CMYK,
        MODE_OTHER
    } t_mode;

    localparam logic [12:0] W_FULL = 13'(SIXTH);

    // half float to unorm16 with saturation, NaN and negatives to zero
    function automatic logic [15:0] half_to_u16(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [10:0] full;
        logic [4:0]  sh;
        logic [27:0] sum;
        logic [27:0] res;
        ex  = h[14:10];
        man = h[9:0];
        if (ex == 5'd0) begin
            full = {1'b0, man};
            sh   = 5'd24;
        end else begin
            full = {1'b1, man};
            sh   = 5'd25 - ex;
        end
        sum = ({1'b0, full, 16'd0} - {17'd0, full}) + (28'd1 << (sh - 5'd1));
        res = sum >> sh;
        if (ex == 5'h1F) begin
            half_to_u16 = (man != 10'd0 || h[15]) ? 16'd0 : UNORM_MAX;
        end else if (h[15]) begin
            half_to_u16 = 16'd0;
        end else if (ex > 5'd15 || (ex == 5'd15 && man != 10'd0)) begin
            half_to_u16 = UNORM_MAX;
        end else begin
            half_to_u16 = res[15:0];
        end
    endfunction

    // HSL weight, expressed as 6000 minus the ramp position
    function automatic logic [12:0] hsl_w(input logic [15:0] t3);
        logic [15:0] d;
        d = 16'd0;
        if (t3 < 16'd6000) begin
            d = 16'(SIXTH) - t3;
        end else if (t3 < 16'd18000) begin
            d = 16'd0;
        end else if (t3 < 16'd24000) begin
            d = t3 - 16'd18000;
        end else begin
            d = 16'(SIXTH);
        end
        hsl_w = d[12:0];
    endfunction

    // ---------------- stage 1: decode ----------------
    logic [15:0] hue2, base, tr_sum, tr, tb;
    logic [2:0]  sec;
    logic        is_hsx, bad, grey;
    t_mode       mode;
    t_side       side;

    always_comb begin
        is_hsx = (i_operation == OP_HSV) || (i_operation == OP_HSL);
        bad    = is_hsx && (i_chan_a > 16'(TURN)) && (i_chan_a != HUE_GREY);
        grey   = (i_chan_b == 16'd0) || (i_chan_a == HUE_GREY);
        hue2   = (i_chan_a == 16'(TURN)) ? 16'd0 : i_chan_a;

        sec  = 3'd0;
        base = 16'd0;
        for (int k = 1; k < 6; k++) begin
            if (hue2 >= 16'(k * SIXTH)) begin
                sec  = 3'(k);
                base = 16'(k * SIXTH);
            end
        end

        tr_sum = hue2 + 16'd12000;
        tr     = (tr_sum > 16'(TURN)) ? tr_sum - 16'(TURN) : tr_sum;
        tb     = (hue2 < 16'd12000) ? hue2 + 16'd24000 : hue2 - 16'd12000;

        side.sel   = SEL_FIXED;
        side.red   = i_chan_a;
        side.green = i_chan_b;
        side.blue  = i_chan_c;
        side.alpha = i_alpha_in;
        side.bad   = bad;
        mode       = MODE_OTHER;
        case (i_operation)
            OP_HSV, OP_HSL: begin
                mode = (i_operation == OP_HSV) ? MODE_HSV : MODE_HSL;
                if (grey) begin
                    side.red   = i_chan_c;
                    side.green = i_chan_c;
                    side.blue  = i_chan_c;
                end else if (bad || (i_operation == OP_HSL && i_chan_c == 16'd0)) begin
                    side.red   = 16'd0;
                    side.green = 16'd0;
                    side.blue  = 16'd0;
                end else begin
                    side.sel = (i_operation == OP_HSV) ? SEL_CALC : SEL_CALC_HSL;
                end
            end
            OP_CMYK: begin
                mode     = MODE_CMYK;
                side.sel = SEL_CALC;
            end
            OP_HALF: begin
                side.red   = half_to_u16(i_chan_a);
                side.green = half_to_u16(i_chan_b);
                side.blue  = half_to_u16(i_chan_c);
                side.alpha = half_to_u16(i_alpha_in);
            end
            default: ;
        endcase
    end

    t_mode       r1_mode;
    logic [15:0] r1_a, r1_b, r1_c, r1_d, r1_hue, r1_tr, r1_tb;
    logic [2:0]  r1_sec;
    logic [12:0] r1_fr;
    t_side       r1_side;
    logic [15:0] fr_full;

    assign fr_full = hue2 - base;

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r1_mode <= mode;
            r1_a    <= i_chan_a;
            r1_b    <= i_chan_b;
            r1_c    <= i_chan_c;
            r1_d    <= i_chan_d;
            r1_hue  <= hue2;
            r1_tr   <= tr;
            r1_tb   <= tb;
            r1_sec  <= sec;
            r1_fr   <= fr_full[12:0];
            r1_side <= side;
        end
    end

    // ---------------- stage 2: weights and products ----------------
    logic [12:0] wq, wt, n_w_r, n_w_g, n_w_b;
    logic [15:0] kk;

    always_comb begin
        wq = r1_fr;
        wt = W_FULL - r1_fr;
        n_w_r = 13'd0;
        n_w_g = 13'd0;
        n_w_b = 13'd0;
        case (r1_mode)
            MODE_HSV: begin
                // value 0, p full, q fr, t 6000 - fr
                case (r1_sec)
                    3'd0: begin n_w_r = 13'd0;  n_w_g = wt;     n_w_b = W_FULL; end
                    3'd1: begin n_w_r = wq;     n_w_g = 13'd0;  n_w_b = W_FULL; end
                    3'd2: begin n_w_r = W_FULL; n_w_g = 13'd0;  n_w_b = wt;     end
                    3'd3: begin n_w_r = W_FULL; n_w_g = wq;     n_w_b = 13'd0;  end
                    3'd4: begin n_w_r = wt;     n_w_g = W_FULL; n_w_b = 13'd0;  end
                    default: begin n_w_r = 13'd0; n_w_g = W_FULL; n_w_b = wq;  end
                endcase
            end
            MODE_HSL: begin
                n_w_r = hsl_w(r1_tr);
                n_w_g = hsl_w(r1_hue);
                n_w_b = hsl_w(r1_tb);
            end
            default: ;
        endcase
        kk = UNORM_MAX - r1_d;
    end

    t_mode       r2_mode;
    logic [15:0] r2_l, r2_s;
    logic [31:0] r2_ls, r2_pc, r2_pm, r2_py;
    logic [12:0] r2_w_r, r2_w_g, r2_w_b;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r2_mode <= r1_mode;
            r2_l    <= r1_c;
            r2_s    <= r1_b;
            r2_ls   <= r1_c * r1_b;
            r2_pc   <= (UNORM_MAX - r1_a) * kk;
            r2_pm   <= (UNORM_MAX - r1_b) * kk;
            r2_py   <= (UNORM_MAX - r1_c) * kk;
            r2_w_r  <= n_w_r;
            r2_w_g  <= n_w_g;
            r2_w_b  <= n_w_b;
            r2_side <= r1_side;
        end
    end

    // ---------------- stage 3: A and B terms ----------------
    logic [32:0] l_un, s_un, s_rest, hsl_a;
    logic [31:0] n_a_r, n_a_g, n_a_b, n_bb;

    always_comb begin
        l_un   = {1'b0, r2_l, 16'd0} - {17'd0, r2_l};
        s_un   = {1'b0, r2_s, 16'd0} - {17'd0, r2_s};
        s_rest = s_un - {1'b0, r2_ls};
        hsl_a  = l_un + (r2_l[15] ? s_rest : {1'b0, r2_ls});
        n_a_r  = 32'd0;
        n_a_g  = 32'd0;
        n_a_b  = 32'd0;
        n_bb   = 32'd0;
        case (r2_mode)
            MODE_HSV: begin
                n_a_r = l_un[31:0];
                n_a_g = l_un[31:0];
                n_a_b = l_un[31:0];
                n_bb  = r2_ls;
            end
            MODE_HSL: begin
                // temp2 - temp1 is twice the offset above the lightness
                n_a_r = hsl_a[31:0];
                n_a_g = hsl_a[31:0];
                n_a_b = hsl_a[31:0];
                n_bb  = r2_l[15] ? {s_rest[30:0], 1'b0} : {r2_ls[30:0], 1'b0};
            end
            MODE_CMYK: begin
                n_a_r = r2_pc;
                n_a_g = r2_pm;
                n_a_b = r2_py;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            o_a_red   <= n_a_r;
            o_a_green <= n_a_g;
            o_a_blue  <= n_a_b;
            o_b       <= n_bb;
            o_w_red   <= r2_w_r;
            o_w_green <= r2_w_g;
            o_w_blue  <= r2_w_b;
            o_side    <= r2_side;
        end
    end

endmodule

// ----- sv/csrgb16_div.sv -----
// ----------------------------------------------------------------------------
// csrgb16_div
// Stages 4 to 7 of one channel: round((A * 6000 - B * w) / (6000 * 65535)).
// Division by 65535 folds the high half onto the low half; division by 6000
// is a reciprocal multiply.
// ----------------------------------------------------------------------------
module csrgb16_div
    import csrgb16_pkg::*;
(
    input  logic        i_clk,
    input  t_div_ld     i_ld,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [12:0] i_w,
    output logic [15:0] o_q
);

    // stage 4: products
    logic [44:0] r4_m, r4_p;

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r4_m <= 45'(i_a * 13'(SIXTH));
            r4_p <= 45'(i_b * i_w);
        end
    end

    // stage 5: numerator plus rounding offset
    logic [45:0] r5_x;

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r5_x <= {1'b0, r4_m} - {1'b0, r4_p} + HALF_DEN;
        end
    end

    // stage 6: floor divide by 65535
    logic [30:0] r1_sum;
    logic [14:0] hi2;
    logic [16:0] r2_sum;
    logic [30:0] q65;
    logic [28:0] r6_q;

    always_comb begin
        r1_sum = {1'b0, r5_x[45:16]} + {15'd0, r5_x[15:0]};
        hi2    = r1_sum[30:16];
        r2_sum = {1'b0, r1_sum[15:0]} + {2'd0, hi2};
        q65    = {1'b0, r5_x[45:16]} + {16'd0, hi2}
                 + ((r2_sum >= 17'(UNORM_MAX)) ? 31'd1 : 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s6) begin
            r6_q <= q65[28:0];
        end
    end

    // stage 7: divide by 6000
    logic [58:0] prod;

    assign prod = r6_q * RECIP_SIXTH;

    always_ff @(posedge i_clk) begin
        if (i_ld.s7) begin
            o_q <= prod[57:42];
        end
    end

endmodule

// ----- sv/color_space_to_rgb16_unit.sv -----
// ----------------------------------------------------------------------------
// color_space_to_rgb16_unit
// Converts one HSV, HSL, CMYK, half-float RGB or RGB pixel to 16-bit ARGB.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_stall | i_operation, i_alpha_in, i_chan_a..i_chan_d
//  output  | o_valid | i_stall | o_red_out, o_green_out, o_blue_out,
//          |         |         | o_alpha_out, o_bad_hue
//
// One pixel per cycle while the output is not stalled; each pixel passes through
// the stage registers (decode, products, A/B terms, scale multiply, subtract,
// fold by 65535, reciprocal multiply by 1/6000, output select).
// Reset clears the stage valid bits only; no state lives between pixels.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module color_space_to_rgb16_unit
    import csrgb16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_alpha_in,
    input  logic [15:0] i_chan_a,
    input  logic [15:0] i_chan_b,
    input  logic [15:0] i_chan_c,
    input  logic [15:0] i_chan_d,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic [15:0] o_alpha_out,
    output logic        o_bad_hue
);

    // stage valid bits and per-stage load enables
    logic [STAGES-1:0] r_vld, n_vld, ld;

    always_comb begin
        ld[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        for (int k = 0; k < STAGES; k++) begin
            if (ld[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !ld[0];
    assign o_valid = r_vld[STAGES-1];

    // front end: stages 1 to 3
    t_prep_ld    prep_ld;
    t_div_ld     div_ld;
    logic [31:0] a_r, a_g, a_b, bb;
    logic [12:0] w_r, w_g, w_b;
    t_side       side3;
    logic [15:0] q_r, q_g, q_b;

    assign prep_ld = '{s1: ld[0], s2: ld[1], s3: ld[2]};
    assign div_ld  = '{s4: ld[3], s5: ld[4], s6: ld[5], s7: ld[6]};

    csrgb16_prep u_prep (
        .i_clk       (i_clk),
        .i_ld        (prep_ld),
        .i_operation (i_operation),
        .i_alpha_in  (i_alpha_in),
        .i_chan_a    (i_chan_a),
        .i_chan_b    (i_chan_b),
        .i_chan_c    (i_chan_c),
        .i_chan_d    (i_chan_d),
        .o_a_red     (a_r),
        .o_a_green   (a_g),
        .o_a_blue    (a_b),
        .o_b         (bb),
        .o_w_red     (w_r),
        .o_w_green   (w_g),
        .o_w_blue    (w_b),
        .o_side      (side3)
    );

    // per-channel scaling and division: stages 4 to 7
    csrgb16_div u_div_red (
        .i_clk (i_clk), .i_ld (div_ld), .i_a (a_r), .i_b (bb), .i_w (w_r), .o_q (q_r)
    );
    csrgb16_div u_div_green (
        .i_clk (i_clk), .i_ld (div_ld), .i_a (a_g), .i_b (bb), .i_w (w_g), .o_q (q_g)
    );
    csrgb16_div u_div_blue (
        .i_clk (i_clk), .i_ld (div_ld), .i_a (a_b), .i_b (bb), .i_w (w_b), .o_q (q_b)
    );

    // side data keeps pace with the divider stages
    t_side r_side [0:3];

    always_ff @(posedge i_clk) begin
        if (ld[3]) r_side[0] <= side3;
        if (ld[4]) r_side[1] <= r_side[0];
        if (ld[5]) r_side[2] <= r_side[1];
        if (ld[6]) r_side[3] <= r_side[2];
    end

    // output select; an HSL channel landing on one code reads as zero
    t_side       sd;
    logic [15:0] n_red, n_green, n_blue;

    always_comb begin
        sd = r_side[3];
        case (sd.sel)
            SEL_CALC: begin
                n_red   = q_r;
                n_green = q_g;
                n_blue  = q_b;
            end
            SEL_CALC_HSL: begin
                n_red   = (q_r == 16'd1) ? 16'd0 : q_r;
                n_green = (q_g == 16'd1) ? 16'd0 : q_g;
                n_blue  = (q_b == 16'd1) ? 16'd0 : q_b;
            end
            default: begin
                n_red   = sd.red;
                n_green = sd.green;
                n_blue  = sd.blue;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[7]) begin
            o_red_out   <= n_red;
            o_green_out <= n_green;
            o_blue_out  <= n_blue;
            o_alpha_out <= sd.alpha;
            o_bad_hue   <= sd.bad;
        end
    end

    // a flagged hue always yields a grey or black pixel
    a_bad_hue_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_hue |-> (o_red_out == o_green_out) && (o_green_out == o_blue_out))
        else $error("bad hue pixel is not grey");

    // an empty first stage never stalls the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> !o_stall)
        else $error("input stalled with empty first stage");

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> !o_valid)
        else $error("output valid right after reset");

    // a valid result held while the output is stalled stays valid
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result lost");

endmodule
